[rtl/fcs_pkg.sv]
// Shared types, sizes and codes for the counting semaphore unit.
package fcs_pkg;

    // Queue depth, token counter width and priority width
    localparam int MAX_WAITERS   = 16;
    localparam int COUNT_BITS    = 16;
    localparam int PRIORITY_BITS = 8;

    // Fixed field widths
    localparam int TASK_ID_BITS = 4;
    localparam int CFG_BITS     = 16;

    // Derived sizes
    localparam int PTR_BITS  = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int FILL_BITS = $clog2(MAX_WAITERS + 1);

    // Stream payload widths, padded to whole bytes
    localparam int IN_FIELD_BITS  = TASK_ID_BITS + PRIORITY_BITS + 1;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = TASK_ID_BITS + 6;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // Operation selector carried on the request side
    typedef enum logic {
        OP_WAIT = 1'b0,
        OP_POST = 1'b1
    } fcs_opcode_t;

    // Error codes
    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_QUEUE_FULL = 2'd1,
        ERR_COUNT_SAT  = 2'd2
    } fcs_error_t;

    // Engine sequencing
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } fcs_state_t;

    // One wait queue entry
    typedef struct packed {
        logic [PRIORITY_BITS-1:0] prio;
        logic [TASK_ID_BITS-1:0]  id;
    } fcs_entry_t;

    localparam int ENTRY_BITS = $bits(fcs_entry_t);

    // One result, granted in the lowest bit
    typedef struct packed {
        fcs_error_t              error;
        logic                    switch_request;
        logic [TASK_ID_BITS-1:0] woken_task;
        logic                    woke_valid;
        logic                    blocked;
        logic                    granted;
    } fcs_result_t;

    // Engine to output register
    typedef struct packed {
        logic        load;
        fcs_result_t result;
    } fcs_out_req_t;

endpackage

[rtl/fcs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/fcs_engine.sv]
// Semaphore engine: token counter, queue pointers and the read-modify-write sequence.
module fcs_engine (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_we,
    input  logic [fcs_pkg::CFG_BITS-1:0]         cfg_data,
    // request side
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  fcs_pkg::fcs_opcode_t                 req_opcode,
    input  logic [fcs_pkg::TASK_ID_BITS-1:0]     req_task_id,
    input  logic [fcs_pkg::PRIORITY_BITS-1:0]    req_prio,
    input  logic                                 req_present,
    // output register
    input  logic                                 out_free,
    output fcs_pkg::fcs_out_req_t                out_req,
    // queue memory
    output logic                                 mem_we,
    output logic [fcs_pkg::PTR_BITS-1:0]         mem_waddr,
    output fcs_pkg::fcs_entry_t                  mem_wdata,
    output logic                                 mem_re,
    output logic [fcs_pkg::PTR_BITS-1:0]         mem_raddr,
    input  fcs_pkg::fcs_entry_t                  mem_rdata
);

    fcs_pkg::fcs_state_t                  state_reg, state_next;
    logic [fcs_pkg::COUNT_BITS-1:0]       count_reg, count_next;
    logic [fcs_pkg::PTR_BITS-1:0]         head_reg, head_next;
    logic [fcs_pkg::PTR_BITS-1:0]         tail_reg, tail_next;
    logic [fcs_pkg::FILL_BITS-1:0]        fill_reg, fill_next;

    // Captured request
    fcs_pkg::fcs_opcode_t                 op_reg;
    logic [fcs_pkg::TASK_ID_BITS-1:0]     id_reg;
    logic [fcs_pkg::PRIORITY_BITS-1:0]    prio_reg;
    logic                                 present_reg;

    logic                                 accept;
    logic                                 queue_full;
    logic                                 queue_empty;
    logic                                 count_zero;
    logic                                 count_max;
    logic [fcs_pkg::PTR_BITS-1:0]         head_inc;
    logic [fcs_pkg::PTR_BITS-1:0]         tail_inc;
    fcs_pkg::fcs_result_t                 result;

    assign req_ready   = (state_reg == fcs_pkg::ST_IDLE);
    assign accept      = req_valid && req_ready;
    assign queue_full  = (fill_reg == fcs_pkg::FILL_BITS'(fcs_pkg::MAX_WAITERS));
    assign queue_empty = (fill_reg == '0);
    assign count_zero  = (count_reg == '0);
    assign count_max   = (count_reg == '1);

    // Ring pointer advance with wrap
    assign head_inc = (head_reg == fcs_pkg::PTR_BITS'(fcs_pkg::MAX_WAITERS - 1))
                      ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == fcs_pkg::PTR_BITS'(fcs_pkg::MAX_WAITERS - 1))
                      ? '0 : tail_reg + 1'b1;

    // Fetch the front entry as the request is taken
    assign mem_re    = accept;
    assign mem_raddr = head_reg;
    assign mem_waddr = tail_reg;
    assign mem_wdata = '{prio: prio_reg, id: id_reg};

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= req_opcode;
            id_reg      <= req_task_id;
            prio_reg    <= req_prio;
            present_reg <= req_present;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fcs_pkg::ST_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            fill_reg  <= fill_next;
        end
    end

    // Next state, counter and queue update
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        fill_next  = fill_reg;
        mem_we     = 1'b0;
        result     = '0;
        out_req    = '0;

        unique case (state_reg)
            fcs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = fcs_pkg::ST_EXEC;
                end
            end
            fcs_pkg::ST_EXEC:
            begin
                // Work out the result from the captured request and the front entry
                if (op_reg == fcs_pkg::OP_WAIT)
                begin
                    if (!count_zero)
                    begin
                        result.granted = 1'b1;
                    end
                    else if (queue_full)
                    begin
                        result.error = fcs_pkg::ERR_QUEUE_FULL;
                    end
                    else
                    begin
                        result.blocked        = 1'b1;
                        result.switch_request = 1'b1;
                    end
                end
                else
                begin
                    if (!queue_empty)
                    begin
                        result.woke_valid     = 1'b1;
                        result.woken_task     = mem_rdata.id;
                        result.switch_request = !present_reg || (mem_rdata.prio < prio_reg);
                    end
                    else if (count_max)
                    begin
                        result.error = fcs_pkg::ERR_COUNT_SAT;
                    end
                end

                // Commit once the output register can take the result
                if (out_free)
                begin
                    out_req.load   = 1'b1;
                    out_req.result = result;
                    state_next     = fcs_pkg::ST_IDLE;
                    if (result.granted)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    if (result.blocked)
                    begin
                        mem_we    = 1'b1;
                        tail_next = tail_inc;
                        fill_next = fill_reg + 1'b1;
                    end
                    if (result.woke_valid)
                    begin
                        head_next = head_inc;
                        fill_next = fill_reg - 1'b1;
                    end
                    if (op_reg == fcs_pkg::OP_POST && queue_empty && !count_max)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = fcs_pkg::ST_IDLE;
            end
        endcase

        // Reload the count and empty the queue
        if (cfg_we)
        begin
            count_next = fcs_pkg::COUNT_BITS'(cfg_data);
            head_next  = '0;
            tail_next  = '0;
            fill_next  = '0;
        end
    end

endmodule

[rtl/fcs_out_reg.sv]
// Result output register: holds one result until the consumer takes it.
module fcs_out_reg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  fcs_pkg::fcs_out_req_t                out_req,
    output logic                                 out_free,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [fcs_pkg::OUT_DATA_BITS-1:0]    m_tdata
);

    logic                 valid_reg, valid_next;
    fcs_pkg::fcs_result_t data_reg;

    assign out_free = !valid_reg || m_tready;

    // Hold valid until taken, set on load
    always_comb
    begin
        valid_next = valid_reg;
        if (out_req.load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (out_req.load)
        begin
            data_reg <= out_req.result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = fcs_pkg::OUT_DATA_BITS'(data_reg);

endmodule

[rtl/fifo_counting_semaphore_unit.sv]
// Top level of the counting semaphore with a first-in first-out wait queue.
//
// Each request passes a take step and an execute step. In the first, the
// request is taken and the queue memory reads the front entry of the wait
// queue into its read register. In the second, once the output register is
// free, the token count and queue pointers are updated, a blocked caller is
// written at the queue tail and the result is loaded into the output
// register. A new request is taken while a finished result still waits
// there, but not before the last one is done. A write on the configuration
// port reloads the token count and empties the wait queue at once; it is
// meant to happen only while no request is in flight.
module fifo_counting_semaphore_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration: reload value for the token count
    input  logic                                 cfg_we,
    input  logic [fcs_pkg::CFG_BITS-1:0]         cfg_data,
    // request stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // bits from low: task_id, task_priority, current_present, zero pad
    input  logic [fcs_pkg::IN_DATA_BITS-1:0]     s_tdata,
    // bits from low: opcode
    input  logic                                 s_tuser,
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // bits from low: granted, blocked, woke_valid, woken_task, switch_request,
    // error, zero pad
    output logic [fcs_pkg::OUT_DATA_BITS-1:0]    m_tdata
);

    localparam int PRIO_LO    = fcs_pkg::TASK_ID_BITS;
    localparam int PRESENT_AT = fcs_pkg::TASK_ID_BITS + fcs_pkg::PRIORITY_BITS;

    fcs_pkg::fcs_out_req_t                out_req;
    logic                                 out_free;
    logic                                 mem_we;
    logic                                 mem_re;
    logic [fcs_pkg::PTR_BITS-1:0]         mem_waddr;
    logic [fcs_pkg::PTR_BITS-1:0]         mem_raddr;
    fcs_pkg::fcs_entry_t                  mem_wdata;
    fcs_pkg::fcs_entry_t                  mem_rdata;
    logic [fcs_pkg::ENTRY_BITS-1:0]       mem_rdata_raw;

    assign mem_rdata = fcs_pkg::fcs_entry_t'(mem_rdata_raw);

    // Counter, pointers and sequencing
    fcs_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_opcode  (fcs_pkg::fcs_opcode_t'(s_tuser)),
        .req_task_id (s_tdata[fcs_pkg::TASK_ID_BITS-1:0]),
        .req_prio    (s_tdata[PRIO_LO +: fcs_pkg::PRIORITY_BITS]),
        .req_present (s_tdata[PRESENT_AT]),
        .out_free    (out_free),
        .out_req     (out_req),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    // Wait queue entries
    fcs_ram #(
        .WIDTH (fcs_pkg::ENTRY_BITS),
        .DEPTH (fcs_pkg::MAX_WAITERS)
    ) u_queue_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata_raw)
    );

    // Result register
    fcs_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .out_req  (out_req),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
